### rtl/core/depth_map_box_smoother_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depth map box smoother
// Concurrent assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DEPTH_MAP_BOX_SMOOTHER_ASSERT_SVH
`define DEPTH_MAP_BOX_SMOOTHER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define DMBS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DMBS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/dmbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmbs_pkg
// Shared types, constants and helpers of the depth map box smoother.
// ----------------------------------------------------------------------------
package dmbs_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	localparam int SAMPLE_W  = 16;
	localparam int SIZE_W    = 11;
	localparam int PIX_W     = 10;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [SIZE_W-1:0] RESET_WIDTH  = 11'd640;
	localparam logic [SIZE_W-1:0] RESET_HEIGHT = 11'd480;

	// window sum: nine 16-bit samples
	localparam int SUM_W = SAMPLE_W + 4;
	// floor((sum + 9*32768 + 4) / 9) == rounded mean + 32768
	localparam int Y_W       = SUM_W;
	localparam int Y_BIAS    = 9 * 32768 + 4;
	localparam int DIV_SHIFT = 24;
	localparam int DIV_MUL_W = 21;
	localparam logic [DIV_MUL_W-1:0] DIV_MUL = 21'd1864136; // ceil(2^24 / 9)
	localparam int PROD_W    = Y_W + DIV_MUL_W;

	localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 16'h8000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    win_sum_t;
	typedef logic [Y_W-1:0]             ydiv_t;
	typedef logic [COL_W-1:0]           col_t;
	typedef logic [ROW_W-1:0]           row_t;
	typedef logic [PIX_W-1:0]           pix_t;

	// one line store entry: row-2 depth, row-1 depth, row-1 variance
	typedef struct packed {
		sample_t up;
		sample_t mid;
		sample_t mid_var;
	} line_word_t;

	typedef struct packed {
		logic       en;
		col_t       addr;
		line_word_t data;
	} ram_wr_t;

	// last column index in use, size clamped to [3, MAX_WIDTH]
	function automatic col_t last_col(input logic [SIZE_W-1:0] v);
		if (v < SIZE_W'(3)) begin
			return COL_W'(2);
		end else if (32'(v) > MAX_WIDTH) begin
			return COL_W'(MAX_WIDTH - 1);
		end
		return COL_W'(v - 1'b1);
	endfunction

	function automatic row_t last_row(input logic [SIZE_W-1:0] v);
		if (v < SIZE_W'(3)) begin
			return ROW_W'(2);
		end else if (32'(v) > MAX_HEIGHT) begin
			return ROW_W'(MAX_HEIGHT - 1);
		end
		return ROW_W'(v - 1'b1);
	endfunction

endpackage

### rtl/core/dmbs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmbs_if
// Valid/ready channels: pixel input and smoothed result output.
// ----------------------------------------------------------------------------
interface dmbs_pix_if;
	import dmbs_pkg::*;
	logic    valid;
	logic    ready;
	sample_t inv_depth;
	sample_t depth_variance;

	modport source (output valid, inv_depth, depth_variance, input ready);
	modport sink   (input valid, inv_depth, depth_variance, output ready);
endinterface

interface dmbs_res_if;
	import dmbs_pkg::*;
	logic    valid;
	logic    ready;
	sample_t smoothed_inv_depth;
	sample_t centre_variance;
	pix_t    pixel_column;
	pix_t    pixel_row;
	logic    frame_last;

	modport source (output valid, smoothed_inv_depth, centre_variance, pixel_column,
		pixel_row, frame_last, input ready);
	modport sink   (input valid, smoothed_inv_depth, centre_variance, pixel_column,
		pixel_row, frame_last, output ready);
endinterface

### rtl/core/dmbs_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmbs_line_ram
// Line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dmbs_line_ram (
	input  logic                 clk,
	input  dmbs_pkg::ram_wr_t    wr,
	input  logic                 rd_en,
	input  dmbs_pkg::col_t       rd_addr,
	output dmbs_pkg::line_word_t rd_data
);
	import dmbs_pkg::*;

	line_word_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/core/dmbs_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmbs_window
// 3x3 inverse-depth window, window sum and centre variance delay.
// ----------------------------------------------------------------------------
module dmbs_window (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift,
	input  dmbs_pkg::sample_t  up,
	input  dmbs_pkg::sample_t  mid,
	input  dmbs_pkg::sample_t  din,
	input  dmbs_pkg::sample_t  mid_var,
	output dmbs_pkg::win_sum_t sum,
	output dmbs_pkg::sample_t  centre_var
);
	import dmbs_pkg::*;

	// oldest two columns; the newest column is the incoming one
	sample_t col1_q [3];
	sample_t col2_q [3];
	sample_t var_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				col1_q[k] <= '0;
				col2_q[k] <= '0;
			end
			var_q <= '0;
		end else if (shift) begin
			for (int k = 0; k < 3; k++) begin
				col1_q[k] <= col2_q[k];
			end
			col2_q[0] <= up;
			col2_q[1] <= mid;
			col2_q[2] <= din;
			var_q     <= mid_var;
		end
	end

	// sum over the window as it stands after this shift
	always_comb begin
		sum = win_sum_t'(up) + win_sum_t'(mid) + win_sum_t'(din);
		for (int k = 0; k < 3; k++) begin
			sum = sum + win_sum_t'(col1_q[k]) + win_sum_t'(col2_q[k]);
		end
	end

	assign centre_var = var_q;

endmodule

### rtl/core/dmbs_div9.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmbs_div9
// Divide by nine through a reciprocal multiply, one registered product.
// ----------------------------------------------------------------------------
module dmbs_div9 (
	input  logic              clk,
	input  logic              en,
	input  dmbs_pkg::ydiv_t   y,
	output dmbs_pkg::sample_t quot
);
	import dmbs_pkg::*;

	logic [PROD_W-1:0] prod_s3;

	// error of the rounded-up reciprocal stays below 1/9 for all y < 2^20
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= PROD_W'(y) * PROD_W'(DIV_MUL);
		end
	end

	assign quot = sample_t'(prod_s3[DIV_SHIFT +: SAMPLE_W]);

endmodule

### rtl/core/depth_map_box_smoother.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_map_box_smoother
// 3x3 box mean of inverse depth over a raster-order depth map stream.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in takes one pixel per beat in raster order (inv_depth, depth_variance).
//   res_out gives one beat per interior pixel: the 3x3 mean of inverse depth,
//   rounded to nearest, the centre pixel's variance, its column/row and a flag
//   on the last interior pixel of the frame. Border pixels give no beat.
//   The result for pixel (r-1, c-1) is formed when pixel (r, c) is accepted.
//   An accepted beat passes stages 1, 2 and 3 before its result is on res_out.
//   Throughput: one pixel per clock while res_out does not stall, set by the
//   line store (one read and one write address per cycle) and the three-stage
//   pipeline behind it. Each stage holds its beat only while the one after it
//   is full and stalled, so pix_in keeps accepting while a result waits on
//   res_out, until all three stages are full.
//   cfg_we/cfg_index/cfg_data write frame_width (0) or frame_height (1);
//   sizes clamp to [3, 1024]; either restarts the frame at row 0, column 0.
//   Reset: sizes 640 x 480, counters and window cleared, pipeline empty.
//   Line store contents are not cleared; they fill as the first rows stream in.
// ----------------------------------------------------------------------------
module depth_map_box_smoother (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dmbs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dmbs_pkg::SIZE_W-1:0]        cfg_data,
	dmbs_pix_if.sink                           pix_in,
	dmbs_res_if.source                         res_out
);
	import dmbs_pkg::*;

	// frame geometry, kept as last index after clamping
	col_t w_last_q;
	row_t h_last_q;
	// position of the next pixel to arrive
	col_t col_q;
	row_t row_q;
	logic restart;

	// stage 1: accepted pixel, line store read in flight
	logic    valid_s1, emit_s1, last_s1;
	sample_t d_s1, v_s1;
	col_t    c_s1;
	pix_t    pcol_s1, prow_s1;

	// stage 2: window sum done
	logic    valid_s2, emit_s2, last_s2;
	ydiv_t   y_s2;
	sample_t cvar_s2;
	pix_t    pcol_s2, prow_s2;

	// stage 3: output register
	logic    valid_s3, last_s3;
	sample_t cvar_s3;
	pix_t    pcol_s3, prow_s3;
	sample_t quot;

	logic rdy_s1, rdy_s2, rdy_s3;
	logic accept, adv_s1, adv_s2;

	line_word_t rd_data;
	ram_wr_t    ram_wr;
	win_sum_t   sum;
	sample_t    centre_var;

	// ---------------- handshake ----------------
	// a stage moves on when the next one is empty or moving too
	assign rdy_s3 = !valid_s3 || res_out.ready;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;
	assign pix_in.ready = rdy_s1;

	assign accept = pix_in.valid && rdy_s1;
	assign adv_s1 = valid_s1 && rdy_s2;
	assign adv_s2 = valid_s2 && rdy_s3;

	// ---------------- configuration ----------------
	always_comb begin
		unique case (cfg_index)
			REG_FRAME_WIDTH, REG_FRAME_HEIGHT: restart = cfg_we;
			default:                           restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= last_col(RESET_WIDTH);
			h_last_q <= last_row(RESET_HEIGHT);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  w_last_q <= last_col(cfg_data);
				REG_FRAME_HEIGHT: h_last_q <= last_row(cfg_data);
				default: ;
			endcase
		end
	end

	// ---------------- raster position ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == w_last_q) begin
				col_q <= '0;
				row_q <= (row_q == h_last_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_s1    <= pix_in.inv_depth;
			v_s1    <= pix_in.depth_variance;
			c_s1    <= col_q;
			emit_s1 <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
			last_s1 <= (row_q == h_last_q) && (col_q == w_last_q);
			pcol_s1 <= PIX_W'(col_q - 1'b1);
			prow_s1 <= PIX_W'(row_q - 1'b1);
		end
	end

	// line store: read at accept, write back the shifted column as the
	// pixel leaves stage 1 (same address only recurs a full row later)
	assign ram_wr.en        = adv_s1;
	assign ram_wr.addr      = c_s1;
	assign ram_wr.data.up   = rd_data.mid;
	assign ram_wr.data.mid  = d_s1;
	assign ram_wr.data.mid_var = v_s1;

	dmbs_line_ram u_line_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data)
	);

	dmbs_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.shift      (adv_s1),
		.up         (rd_data.up),
		.mid        (rd_data.mid),
		.din        (d_s1),
		.mid_var    (rd_data.mid_var),
		.sum        (sum),
		.centre_var (centre_var)
	);

	// ---------------- stage 2 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// bias makes the dividend non-negative and folds in the rounding
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			y_s2    <= ydiv_t'(sum) + Y_W'(Y_BIAS);
			cvar_s2 <= centre_var;
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
			pcol_s2 <= pcol_s1;
			prow_s2 <= prow_s1;
		end
	end

	// ---------------- stage 3 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= valid_s2 && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			cvar_s3 <= cvar_s2;
			last_s3 <= last_s2;
			pcol_s3 <= pcol_s2;
			prow_s3 <= prow_s2;
		end
	end

	dmbs_div9 u_div9 (
		.clk  (clk),
		.en   (adv_s2),
		.y    (y_s2),
		.quot (quot)
	);

	// quotient carries a +32768 offset; flipping the sign bit removes it
	assign res_out.valid              = valid_s3;
	assign res_out.smoothed_inv_depth = quot ^ SIGN_FLIP;
	assign res_out.centre_variance    = cvar_s3;
	assign res_out.pixel_column       = pcol_s3;
	assign res_out.pixel_row          = prow_s3;
	assign res_out.frame_last         = last_s3;

endmodule

### rtl/core/dmbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmbs_checker
// Port-level assertions for the depth map box smoother, bound to the top.
// ----------------------------------------------------------------------------
`include "depth_map_box_smoother_assert.svh"

module dmbs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input dmbs_pkg::sample_t smoothed,
	input dmbs_pkg::sample_t cvar,
	input dmbs_pkg::pix_t    pcol,
	input dmbs_pkg::pix_t    prow,
	input logic              last
);
	import dmbs_pkg::*;

	logic out_busy;
	assign out_busy = out_valid && !out_ready;

	`DMBS_ASSERT_NXT(a_stall_hold, clk, arst_n, out_busy,
		out_valid && $stable(smoothed) && $stable(cvar) && $stable(pcol) &&
		$stable(prow) && $stable(last), "result changed while stalled")

	`DMBS_ASSERT_IMP(a_interior_only, clk, arst_n, out_valid,
		(pcol != '0) && (prow != '0), "border pixel emitted")

	`DMBS_ASSERT_IMP(a_ready_follows, clk, arst_n, out_ready && !in_ready,
		1'b0, "input stalled while output drains")

	`DMBS_ASSERT_NXT(a_frame_gap, clk, arst_n, out_valid && out_ready && last,
		!out_valid, "result right after frame end")

endmodule

bind depth_map_box_smoother dmbs_checker u_dmbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (res_out.valid),
	.out_ready (res_out.ready),
	.smoothed  (res_out.smoothed_inv_depth),
	.cvar      (res_out.centre_variance),
	.pcol      (res_out.pixel_column),
	.prow      (res_out.pixel_row),
	.last      (res_out.frame_last)
);

### tb/tb_depth_map_box_smoother.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_map_box_smoother
// Self-checking bench for the 3x3 inverse-depth box smoother. Pixels stream in
// raster order under several frame sizes; a bit-exact predictor of the line
// stores, window and counters produces each expected result beat, and every
// beat on res_out is compared field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_depth_map_box_smoother;
	import dmbs_pkg::*;

	// sizes the block must come out of reset with
	localparam int FRAME_WIDTH_AT_RESET  = 640;
	localparam int FRAME_HEIGHT_AT_RESET = 480;

	// index values outside the register map; a write to one is dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int RANDOM_ITEMS   = 400;   // back-pressure phase plus random phases
	localparam int PRESSURE_ITEMS = 150;
	localparam int DIRECTED_ROWS  = 27;
	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
	localparam int DRAIN_CYCLES   = 8;     // time for the pipe to empty, plus margin
	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either side
	localparam int MAX_SHOWN      = 10;

	typedef struct packed {
		sample_t depth_mean;
		sample_t centre_var;
		pix_t    col;
		pix_t    row;
		logic    last;
	} smooth_res_t;

	// one directed pixel; typed rows carry a hand-worked result
	typedef struct packed {
		sample_t depth;
		sample_t variance;
		logic    typed;
		sample_t mean_hand;
		sample_t var_hand;
	} dir_row_t;

	typedef enum int {FILL_FULL, FILL_EXTREME, FILL_NEAR_ZERO} fill_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKED, RX_HOLD} rx_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0]    cfg_data;

	dmbs_pix_if pix_bus ();
	dmbs_res_if res_bus ();

	depth_map_box_smoother u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (pix_bus),
		.res_out   (res_bus)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------------
	// Predictor state: two depth lines, one variance line, the 3x3 window,
	// the raster position of the next pixel and the one-deep variance delay.
	// ------------------------------------------------------------------------
	logic [SIZE_W-1:0] width_cfg;
	logic [SIZE_W-1:0] height_cfg;
	sample_t           depth_two_back    [MAX_WIDTH];
	sample_t           depth_one_back    [MAX_WIDTH];
	sample_t           variance_one_back [MAX_WIDTH];
	sample_t           window [9];
	int                col_pos;
	int                row_pos;
	sample_t           variance_hold;

	smooth_res_t awaited_means [$];  // expected result beats, oldest first
	smooth_res_t typed_checks  [$];  // hand-worked results from the table
	int          fault_count = 0;
	int          burst_left  = 0;
	bit          steady_sender = 1'b0;
	bit          hold_off_req  = 1'b0;

	// Directed frames, all 3x3. Frames one and two are uniform at the depth
	// extremes, so the mean is the extreme itself and the centre variance is
	// the fifth pixel's. Frame three mixes extremes with small values and is
	// left to the predictor.
	dir_row_t directed_rows [DIRECTED_ROWS] = '{
		'{16'sh7FFF, 16'sh1000, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh7FFF, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh7FFF, 16'shFFFF, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh7FFF, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh7FFF, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh7FFF, 16'sh0001, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh7FFF, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh7FFF, 16'sh5555, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh7FFF, 16'shAAAA, 1'b1, 16'sh7FFF, 16'sh8000},
		'{16'sh8000, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh8000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh8000, 16'sh0001, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh8000, 16'shFFFF, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh8000, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh8000, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh8000, 16'sh1234, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh8000, 16'shEDCB, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh8000, 16'sh0000, 1'b1, 16'sh8000, 16'sh7FFF},
		'{16'sh7FFF, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh8000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh0005, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{16'shFFFB, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh0001, 16'shFFF0, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{16'shFFFF, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{16'sh0003, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000}
	};

	// size as the block uses it: below 3 acts as 3, above the store as the store
	function automatic int usable_size(input logic [SIZE_W-1:0] v, input int limit);
		if (v < 3) begin
			return 3;
		end
		if (int'(v) > limit) begin
			return limit;
		end
		return int'(v);
	endfunction

	function automatic void clear_predictor();
		width_cfg     = SIZE_W'(FRAME_WIDTH_AT_RESET);
		height_cfg    = SIZE_W'(FRAME_HEIGHT_AT_RESET);
		col_pos       = 0;
		row_pos       = 0;
		variance_hold = '0;
		for (int k = 0; k < 9; k++) begin
			window[k] = '0;
		end
		for (int k = 0; k < MAX_WIDTH; k++) begin
			depth_two_back[k]    = '0;
			depth_one_back[k]    = '0;
			variance_one_back[k] = '0;
		end
	endfunction

	// Takes one accepted pixel, advances the predictor and returns 1 with the
	// result when the pixel completes the window of an interior pixel.
	function automatic bit compute_box_mean(input sample_t d, input sample_t v,
			output smooth_res_t res);
		int      w;
		int      h;
		int      c;
		int      r;
		int      acc;
		int      q;
		bit      emits;
		sample_t centre;

		w = usable_size(width_cfg, MAX_WIDTH);
		h = usable_size(height_cfg, MAX_HEIGHT);
		c = (col_pos >= w) ? 0 : col_pos;
		r = (row_pos >= h) ? 0 : row_pos;

		for (int k = 0; k < 3; k++) begin
			window[k * 3]     = window[k * 3 + 1];
			window[k * 3 + 1] = window[k * 3 + 2];
		end
		window[2] = depth_two_back[c];
		window[5] = depth_one_back[c];
		window[8] = d;

		// the centre is one column behind the newest, hence the delay
		centre        = variance_hold;
		variance_hold = variance_one_back[c];

		depth_two_back[c]    = depth_one_back[c];
		depth_one_back[c]    = d;
		variance_one_back[c] = v;

		emits = (r >= 2) && (c >= 2);
		res   = '0;
		if (emits) begin
			acc = 0;
			for (int k = 0; k < 9; k++) begin
				acc += int'(window[k]);
			end
			// bias to positive so the division floors; sum/9 never ties
			q = (2 * (acc + 9 * 32768) + 9) / 18 - 32768;
			res.depth_mean = sample_t'(q);
			res.centre_var = centre;
			res.col        = pix_t'(c - 1);
			res.row        = pix_t'(r - 1);
			res.last       = (r == h - 1) && (c == w - 1);
		end

		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) begin
				r = 0;
			end
		end
		col_pos = c;
		row_pos = r;
		return emits;
	endfunction

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_SHOWN) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	// ------------------------------------------------------------------------
	// Scoreboard. Result beats are checked before the input beat of the same
	// edge is predicted; with pipeline stages between them they never belong together.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		smooth_res_t got;
		smooth_res_t want;
		smooth_res_t calc;

		if (arst_n) begin
			if (res_bus.valid && res_bus.ready) begin
				got.depth_mean = res_bus.smoothed_inv_depth;
				got.centre_var = res_bus.centre_variance;
				got.col        = res_bus.pixel_column;
				got.row        = res_bus.pixel_row;
				got.last       = res_bus.frame_last;
				if (awaited_means.size() == 0) begin
					note_fault($sformatf("unexpected beat: mean %0d var %0d at (%0d,%0d) last %0b",
						got.depth_mean, got.centre_var, got.row, got.col, got.last));
				end else begin
					want = awaited_means.pop_front();
					if (got.depth_mean !== want.depth_mean || got.centre_var !== want.centre_var
							|| got.col !== want.col || got.row !== want.row
							|| got.last !== want.last) begin
						note_fault($sformatf({"mismatch: expected mean %0d var %0d (%0d,%0d) last %0b,",
							" got mean %0d var %0d (%0d,%0d) last %0b"},
							want.depth_mean, want.centre_var, want.row, want.col, want.last,
							got.depth_mean, got.centre_var, got.row, got.col, got.last));
					end
				end
			end
			if (pix_bus.valid && pix_bus.ready) begin
				if (compute_box_mean(pix_bus.inv_depth, pix_bus.depth_variance, calc)) begin
					if (typed_checks.size() != 0) begin
						calc = typed_checks.pop_front();
					end
					awaited_means.push_back(calc);
				end
			end
		end
	end

	// Watchdog: ends the run if neither channel moves a beat for too long.
	initial begin : watchdog
		int idle_cycles;

		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("depth_map_box_smoother verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver: segments of open, coin-flip, every-third and blocked ready.
	// A hold-off request from the stimulus turns into one long blocked stretch
	// so the pipe fills up and pix_in stalls.
	// ------------------------------------------------------------------------
	initial begin : receiver
		rx_mode_t mode;
		int       span;

		res_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = (mode == RX_BLOCKED) ? $urandom_range(1, 16) : $urandom_range(4, 64);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				mode         = RX_HOLD;
				span         = HOLD_CYCLES;
			end
			for (int i = 0; i < span; i++) begin
				@(posedge clk);
				case (mode)
					RX_OPEN: begin
						res_bus.ready <= 1'b1;
					end
					RX_COIN: begin
						res_bus.ready <= 1'($urandom_range(0, 1));
					end
					RX_SPARSE: begin
						res_bus.ready <= (i % 3 == 0);
					end
					default: begin
						res_bus.ready <= 1'b0;
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender helpers. The sender works in bursts with random gaps unless the
	// current phase asks for a steady stream. valid stays high from one beat
	// to the next within a burst.
	// ------------------------------------------------------------------------
	task automatic push_pixel(input sample_t d, input sample_t v);
		int gap;

		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if (!steady_sender) begin
				gap = $urandom_range(1, 12);
				pix_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pix_bus.valid          <= 1'b1;
		pix_bus.inv_depth      <= d;
		pix_bus.depth_variance <= v;
		do begin
			@(posedge clk);
		end while (!pix_bus.ready);
	endtask

	function automatic sample_t draw_sample(input fill_t fill);
		case (fill)
			FILL_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			FILL_NEAR_ZERO: begin
				return sample_t'(int'($urandom_range(0, 40)) - 20);
			end
			default: begin
				return sample_t'($urandom);
			end
		endcase
	endfunction

	task automatic stream_pixels(input int count, input fill_t fill);
		for (int i = 0; i < count; i++) begin
			push_pixel(draw_sample(fill), sample_t'($urandom));
		end
		pix_bus.valid <= 1'b0;
	endtask

	// Registers change only with the block empty: all awaited beats in, then
	// DRAIN_CYCLES more for border pixels still in the pipe.
	task automatic wait_drained();
		while (awaited_means.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		// a write to a mapped register restarts the frame; others are dropped
		if (idx == REG_FRAME_WIDTH) begin
			width_cfg = val;
			col_pos   = 0;
			row_pos   = 0;
		end else if (idx == REG_FRAME_HEIGHT) begin
			height_cfg = val;
			col_pos    = 0;
			row_pos    = 0;
		end
		cfg_we <= 1'b0;
	endtask

	// mostly small sizes, some below the minimum, a few wider ones
	function automatic logic [SIZE_W-1:0] pick_size(input int typical_max, input int wide_max);
		int roll;

		roll = $urandom_range(0, 19);
		if (roll < 3) begin
			return SIZE_W'($urandom_range(0, 2));
		end
		if (roll < 6) begin
			return SIZE_W'($urandom_range(typical_max + 1, wide_max));
		end
		return SIZE_W'($urandom_range(3, typical_max));
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int          random_sent;
		int          ew;
		int          eh;
		int          npix;
		int          mode;
		smooth_res_t hand;

		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= REG_FRAME_WIDTH;
		cfg_data               <= '0;
		pix_bus.valid          <= 1'b0;
		pix_bus.inv_depth      <= '0;
		pix_bus.depth_variance <= '0;
		clear_predictor();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes: two rows of 640 and a few pixels of the third, enough
		// to see the first interior results land at the right columns.
		steady_sender = 1'b0;
		stream_pixels(2 * FRAME_WIDTH_AT_RESET + 5, FILL_FULL);

		// Directed table. Sizes 0 and 2 both act as 3, giving 3x3 frames with
		// a single result on the ninth pixel, flagged last.
		wait_drained();
		write_reg(REG_FRAME_WIDTH, SIZE_W'(0));
		write_reg(REG_FRAME_HEIGHT, SIZE_W'(2));
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_rows[i].typed) begin
				hand.depth_mean = directed_rows[i].mean_hand;
				hand.centre_var = directed_rows[i].var_hand;
				hand.col        = pix_t'(1);
				hand.row        = pix_t'(1);
				hand.last       = 1'b1;
				typed_checks.push_back(hand);
			end
			push_pixel(directed_rows[i].depth, directed_rows[i].variance);
		end
		pix_bus.valid <= 1'b0;

		// Back-pressure: a steady stream into a small frame while the
		// receiver holds off, so all stages fill and pix_in stalls.
		random_sent = 0;
		wait_drained();
		write_reg(REG_FRAME_WIDTH, SIZE_W'(4));
		write_reg(REG_FRAME_HEIGHT, SIZE_W'(6));
		steady_sender = 1'b1;
		hold_off_req  = 1'b1;
		stream_pixels(PRESSURE_ITEMS, FILL_FULL);
		random_sent += PRESSURE_ITEMS;

		// Random phases: mostly whole frames of small sizes with random
		// content, plus cut frames, restarts by rewriting a register, and
		// writes to unmapped indexes that must not disturb the frame.
		while (random_sent < RANDOM_ITEMS) begin
			wait_drained();
			mode = $urandom_range(0, 5);
			case (mode)
				1: begin
					write_reg(REG_FRAME_WIDTH, pick_size(12, 40));
				end
				2: begin
					write_reg(REG_FRAME_HEIGHT, pick_size(8, 20));
				end
				3, 4: begin
					write_reg(REG_FRAME_WIDTH, pick_size(12, 40));
					write_reg(REG_FRAME_HEIGHT, pick_size(8, 20));
				end
				5: begin
					write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
						SIZE_W'($urandom));
				end
				default: begin
				end
			endcase
			ew   = usable_size(width_cfg, MAX_WIDTH);
			eh   = usable_size(height_cfg, MAX_HEIGHT);
			npix = $urandom_range(1, 2) * ew * eh;
			if (npix > 500) begin
				npix = ew * eh;
			end
			if ($urandom_range(0, 2) == 0) begin
				npix = $urandom_range(1, npix + ew * eh / 2);
			end
			// keep the total near the item budget
			if (npix > RANDOM_ITEMS - random_sent) begin
				npix = RANDOM_ITEMS - random_sent;
			end
			steady_sender = ($urandom_range(0, 3) == 0);
			stream_pixels(npix, fill_t'($urandom_range(0, 2)));
			random_sent += npix;
		end

		// wait out the tail; the watchdog bounds this
		wait_drained();
		repeat (20) @(posedge clk);
		if (fault_count == 0) begin
			$display("depth_map_box_smoother verification clean");
		end else begin
			$display("depth_map_box_smoother verification failed");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/dmbs_pkg.sv
rtl/core/dmbs_if.sv
rtl/core/dmbs_line_ram.sv
rtl/core/dmbs_window.sv
rtl/core/dmbs_div9.sv
rtl/core/depth_map_box_smoother.sv
rtl/core/dmbs_checker.sv
tb/tb_depth_map_box_smoother.sv
